>>> sv/periodic_task_scheduler_assert.svh
// ----------------------------------------------------------------------------
// Periodic task scheduler assertion macros
// Immediate-consequence and next-cycle property checks on clk, disabled in rst.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TASK_SCHEDULER_ASSERT_SVH
`define PERIODIC_TASK_SCHEDULER_ASSERT_SVH

`define PTS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`define PTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/pts_pkg.sv
// ----------------------------------------------------------------------------
// Periodic task scheduler package
// Shared constants, controller states and controller/datapath interface types.
// ----------------------------------------------------------------------------
package pts_pkg;

  localparam int MAX_TASKS_DEFAULT = 8;
  localparam int DATA_W            = 32;
  localparam int WAIT_W            = 31;
  localparam int OUT_IDX_W         = 3;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_POLL = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD,
    ST_EMPTY,
    ST_SCAN1,
    ST_CHECK,
    ST_PER_RD,
    ST_UPD,
    ST_SCAN2,
    ST_RESULT
  } pts_state_t;

  typedef struct packed {
    logic load;
    logic scan_clr;
    logic scan_run;
    logic check;
    logic per_rd;
    logic upd;
    logic add_wr;
    logic emit_add;
    logic emit_poll;
    logic emit_empty;
  } pts_cmd_t;

  typedef struct packed {
    logic empty;
    logic scan_done;
    logic fire;
  } pts_stat_t;

endpackage

>>> sv/pts_ctrl.sv
// ----------------------------------------------------------------------------
// Periodic task scheduler controller
// Sequences add, table scans, due-time update and result strobe.
// ----------------------------------------------------------------------------
module pts_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              op,
  input  pts_pkg::pts_stat_t stat,
  output pts_pkg::pts_cmd_t  cmd_o,
  output logic              busy
);

  pts_pkg::pts_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pts_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pts_pkg::ST_IDLE: begin
        if (start) begin
          if (op == pts_pkg::CMD_ADD) begin
            state_next = pts_pkg::ST_ADD;
          end else if (stat.empty) begin
            state_next = pts_pkg::ST_EMPTY;
          end else begin
            state_next = pts_pkg::ST_SCAN1;
          end
        end
      end
      pts_pkg::ST_ADD:    state_next = pts_pkg::ST_IDLE;
      pts_pkg::ST_EMPTY:  state_next = pts_pkg::ST_IDLE;
      pts_pkg::ST_SCAN1: begin
        if (stat.scan_done) state_next = pts_pkg::ST_CHECK;
      end
      pts_pkg::ST_CHECK: begin
        state_next = stat.fire ? pts_pkg::ST_PER_RD : pts_pkg::ST_RESULT;
      end
      pts_pkg::ST_PER_RD: state_next = pts_pkg::ST_UPD;
      pts_pkg::ST_UPD:    state_next = pts_pkg::ST_SCAN2;
      pts_pkg::ST_SCAN2: begin
        if (stat.scan_done) state_next = pts_pkg::ST_RESULT;
      end
      pts_pkg::ST_RESULT: state_next = pts_pkg::ST_IDLE;
      default:            state_next = pts_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state)
      pts_pkg::ST_IDLE: begin
        cmd_o.load     = start;
        cmd_o.scan_clr = start;
      end
      pts_pkg::ST_ADD: begin
        cmd_o.add_wr   = 1'b1;
        cmd_o.emit_add = 1'b1;
      end
      pts_pkg::ST_EMPTY:  cmd_o.emit_empty = 1'b1;
      pts_pkg::ST_SCAN1:  cmd_o.scan_run   = 1'b1;
      pts_pkg::ST_CHECK:  cmd_o.check      = 1'b1;
      pts_pkg::ST_PER_RD: cmd_o.per_rd     = 1'b1;
      pts_pkg::ST_UPD: begin
        cmd_o.upd      = 1'b1;
        cmd_o.scan_clr = 1'b1;
      end
      pts_pkg::ST_SCAN2:  cmd_o.scan_run   = 1'b1;
      pts_pkg::ST_RESULT: cmd_o.emit_poll  = 1'b1;
      default:            cmd_o = '0;
    endcase
  end

  assign busy = (state != pts_pkg::ST_IDLE);

endmodule

>>> sv/pts_dp.sv
// ----------------------------------------------------------------------------
// Periodic task scheduler datapath
// Task table memories, earliest-due scan, due-time update and result registers.
// ----------------------------------------------------------------------------
module pts_dp #(
  parameter int MAX_TASKS = pts_pkg::MAX_TASKS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  pts_pkg::pts_cmd_t                    cmd_i,
  output pts_pkg::pts_stat_t                   stat,
  input  logic signed [pts_pkg::DATA_W-1:0]    now_ms,
  input  logic signed [pts_pkg::DATA_W-1:0]    first_delay_ms,
  input  logic signed [pts_pkg::DATA_W-1:0]    period_ms,
  output logic                                 done,
  output logic                                 fired,
  output logic [pts_pkg::OUT_IDX_W-1:0]        fired_task,
  output logic                                 no_tasks,
  output logic [pts_pkg::WAIT_W-1:0]           wait_ms,
  output logic                                 add_accepted,
  output logic [pts_pkg::OUT_IDX_W-1:0]        add_index
);

  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = $clog2(MAX_TASKS + 1);

  logic signed [pts_pkg::DATA_W-1:0] due_mem [MAX_TASKS];
  logic signed [pts_pkg::DATA_W-1:0] per_mem [MAX_TASKS];

  logic signed [pts_pkg::DATA_W-1:0] now_r, delay_r, period_r;
  logic [CNT_W-1:0]                  count;
  logic [CNT_W-1:0]                  sc;
  logic                              pend;
  logic [IDX_W-1:0]                  pend_idx;
  logic signed [pts_pkg::DATA_W-1:0] due_q, per_q;
  logic signed [pts_pkg::DATA_W-1:0] best_due;
  logic [IDX_W-1:0]                  best_idx;
  logic                              best_valid;
  logic                              fire_r;
  logic [IDX_W-1:0]                  fire_idx;

  logic                              room;
  logic [IDX_W-1:0]                  rd_addr;
  logic [IDX_W-1:0]                  wr_addr;
  logic                              due_we;
  logic signed [pts_pkg::DATA_W-1:0] due_wdata;
  logic [pts_pkg::DATA_W-1:0]        delta;
  logic [CNT_W+2:0]                  cnt_ext;
  logic [IDX_W+2:0]                  fire_ext;

  assign room      = (count < CNT_W'(MAX_TASKS));
  assign rd_addr   = cmd_i.per_rd ? best_idx : sc[IDX_W-1:0];
  assign wr_addr   = cmd_i.upd ? best_idx : count[IDX_W-1:0];
  assign due_we    = cmd_i.upd || (cmd_i.add_wr && room);
  assign due_wdata = cmd_i.upd ? (best_due + per_q) : (now_r + delay_r);
  assign delta     = best_due - now_r - 32'sd1;
  assign cnt_ext   = {3'b000, count};
  assign fire_ext  = {3'b000, fire_idx};

  assign stat.empty     = (count == '0);
  assign stat.scan_done = (sc == count) && !pend;
  assign stat.fire      = !(now_r < best_due);

  always_ff @(posedge clk) begin
    if (due_we) due_mem[wr_addr] <= due_wdata;
    if (cmd_i.add_wr && room) per_mem[wr_addr] <= period_r;
    due_q <= due_mem[rd_addr];
    per_q <= per_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      now_r    <= now_ms;
      delay_r  <= first_delay_ms;
      period_r <= period_ms;
    end
    if (cmd_i.scan_run && pend) begin
      if (!best_valid || (due_q < best_due)) begin
        best_due <= due_q;
        best_idx <= pend_idx;
      end
    end
    if (cmd_i.scan_run && (sc != count)) pend_idx <= sc[IDX_W-1:0];
    if (cmd_i.check) fire_idx <= best_idx;
    if (cmd_i.emit_add) begin
      fired        <= 1'b0;
      fired_task   <= '0;
      no_tasks     <= 1'b0;
      wait_ms      <= '0;
      add_accepted <= room;
      add_index    <= room ? cnt_ext[pts_pkg::OUT_IDX_W-1:0] : '0;
    end else if (cmd_i.emit_empty) begin
      fired        <= 1'b0;
      fired_task   <= '0;
      no_tasks     <= 1'b1;
      wait_ms      <= '0;
      add_accepted <= 1'b0;
      add_index    <= '0;
    end else if (cmd_i.emit_poll) begin
      fired        <= fire_r;
      fired_task   <= fire_r ? fire_ext[pts_pkg::OUT_IDX_W-1:0] : '0;
      no_tasks     <= 1'b0;
      wait_ms      <= delta[pts_pkg::DATA_W-1] ? '0 : delta[pts_pkg::WAIT_W-1:0];
      add_accepted <= 1'b0;
      add_index    <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      sc         <= '0;
      pend       <= 1'b0;
      best_valid <= 1'b0;
      fire_r     <= 1'b0;
      done       <= 1'b0;
    end else begin
      done <= cmd_i.emit_add || cmd_i.emit_poll || cmd_i.emit_empty;
      if (cmd_i.add_wr && room) count <= count + 1'b1;
      if (cmd_i.load) fire_r <= 1'b0;
      if (cmd_i.check) fire_r <= stat.fire;
      if (cmd_i.scan_clr) begin
        sc         <= '0;
        pend       <= 1'b0;
        best_valid <= 1'b0;
      end else if (cmd_i.scan_run) begin
        if (pend) best_valid <= 1'b1;
        if (sc != count) begin
          sc   <= sc + 1'b1;
          pend <= 1'b1;
        end else begin
          pend <= 1'b0;
        end
      end
    end
  end

endmodule

>>> sv/periodic_task_scheduler.sv
// ----------------------------------------------------------------------------
// Periodic task scheduler: add stores a task and strobes done; poll scans the
// N tasks held (one table entry read per cycle), and scans again when a task fires.
// One request at a time; done is a one-cycle strobe the receiver cannot stall.
// Synchronous rst empties the table; entries hold no value until written.
// ----------------------------------------------------------------------------
`include "periodic_task_scheduler_assert.svh"

module periodic_task_scheduler #(
  parameter int MAX_TASKS = pts_pkg::MAX_TASKS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              cmd,
  input  logic signed [pts_pkg::DATA_W-1:0] now_ms,
  input  logic signed [pts_pkg::DATA_W-1:0] first_delay_ms,
  input  logic signed [pts_pkg::DATA_W-1:0] period_ms,
  output logic                              done,
  output logic                              fired,
  output logic [pts_pkg::OUT_IDX_W-1:0]     fired_task,
  output logic                              no_tasks,
  output logic [pts_pkg::WAIT_W-1:0]        wait_ms,
  output logic                              add_accepted,
  output logic [pts_pkg::OUT_IDX_W-1:0]     add_index
);

  pts_pkg::pts_cmd_t  dp_cmd;
  pts_pkg::pts_stat_t dp_stat;

  pts_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (cmd),
    .stat  (dp_stat),
    .cmd_o (dp_cmd),
    .busy  (busy)
  );

  pts_dp #(
    .MAX_TASKS (MAX_TASKS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd_i          (dp_cmd),
    .stat           (dp_stat),
    .now_ms         (now_ms),
    .first_delay_ms (first_delay_ms),
    .period_ms      (period_ms),
    .done           (done),
    .fired          (fired),
    .fired_task     (fired_task),
    .no_tasks       (no_tasks),
    .wait_ms        (wait_ms),
    .add_accepted   (add_accepted),
    .add_index      (add_index)
  );

  `PTS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "request accepted but not busy")
  `PTS_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while still busy")
  `PTS_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe longer than one cycle")
  `PTS_ASSERT_NOW(a_result_kind, done && (fired || no_tasks), !add_accepted,
                  "poll result flagged as accepted add")

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// Periodic task scheduler testbench
// Sends add and poll requests through the start/busy handshake, predicts each
// done strobe from a local copy of the task table and checks every field.
// Directed requests cover the empty table, ties, wrap and a full table; random
// polls then track the earliest due time so that tasks keep firing.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int NUM_RANDOM = 1230;
  localparam int QUIET_TAIL = 200;
  localparam logic signed [pts_pkg::DATA_W-1:0] INT_MAX = 32'sh7fffffff;
  localparam logic signed [pts_pkg::DATA_W-1:0] INT_MIN = 32'sh80000000;

  typedef struct {
    logic                          fired;
    logic [pts_pkg::OUT_IDX_W-1:0] fired_task;
    logic                          no_tasks;
    logic [pts_pkg::WAIT_W-1:0]    wait_ms;
    logic                          add_accepted;
    logic [pts_pkg::OUT_IDX_W-1:0] add_index;
  } sched_result_t;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  logic cmd;
  logic signed [pts_pkg::DATA_W-1:0] now_ms;
  logic signed [pts_pkg::DATA_W-1:0] first_delay_ms;
  logic signed [pts_pkg::DATA_W-1:0] period_ms;
  logic done;
  logic fired;
  logic [pts_pkg::OUT_IDX_W-1:0] fired_task;
  logic no_tasks;
  logic [pts_pkg::WAIT_W-1:0] wait_ms;
  logic add_accepted;
  logic [pts_pkg::OUT_IDX_W-1:0] add_index;

  // local copy of the task table
  logic signed [pts_pkg::DATA_W-1:0] due_tbl [pts_pkg::MAX_TASKS_DEFAULT];
  logic signed [pts_pkg::DATA_W-1:0] period_tbl [pts_pkg::MAX_TASKS_DEFAULT];
  int unsigned n_tasks;

  sched_result_t pending_q[$];

  int n_requests, n_added, n_refused, n_polls, n_fired, n_empty;
  int n_mismatch;

  periodic_task_scheduler dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .cmd            (cmd),
    .now_ms         (now_ms),
    .first_delay_ms (first_delay_ms),
    .period_ms      (period_ms),
    .done           (done),
    .fired          (fired),
    .fired_task     (fired_task),
    .no_tasks       (no_tasks),
    .wait_ms        (wait_ms),
    .add_accepted   (add_accepted),
    .add_index      (add_index)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int earliest_task();
    int best;
    best = 0;
    for (int i = 1; i < n_tasks; i++) begin
      if (due_tbl[i] < due_tbl[best]) best = i;
    end
    return best;
  endfunction

  task automatic predict_request(input logic c,
                                 input logic signed [pts_pkg::DATA_W-1:0] now,
                                 input logic signed [pts_pkg::DATA_W-1:0] delay,
                                 input logic signed [pts_pkg::DATA_W-1:0] period);
    sched_result_t r;
    int k;
    logic [pts_pkg::DATA_W-1:0] delta;
    r = '{fired: 1'b0, fired_task: '0, no_tasks: 1'b0, wait_ms: '0,
          add_accepted: 1'b0, add_index: '0};
    if (c == pts_pkg::CMD_ADD) begin
      if (n_tasks < pts_pkg::MAX_TASKS_DEFAULT) begin
        due_tbl[n_tasks]    = now + delay;
        period_tbl[n_tasks] = period;
        r.add_accepted      = 1'b1;
        r.add_index         = n_tasks[pts_pkg::OUT_IDX_W-1:0];
        n_tasks++;
        n_added++;
      end else begin
        n_refused++;
      end
    end else begin
      n_polls++;
      if (n_tasks == 0) begin
        r.no_tasks = 1'b1;
        n_empty++;
      end else begin
        k = earliest_task();
        if (!(now < due_tbl[k])) begin
          r.fired      = 1'b1;
          r.fired_task = k[pts_pkg::OUT_IDX_W-1:0];
          due_tbl[k]   = due_tbl[k] + period_tbl[k];
          n_fired++;
        end
        k = earliest_task();
        delta = due_tbl[k] - now - 32'sd1;
        r.wait_ms = delta[pts_pkg::DATA_W-1] ? '0 : delta[pts_pkg::WAIT_W-1:0];
      end
    end
    pending_q.push_back(r);
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  // with start still high, so back-to-back requests need no extra step
  task automatic send_request(input logic c,
                              input logic signed [pts_pkg::DATA_W-1:0] now,
                              input logic signed [pts_pkg::DATA_W-1:0] delay,
                              input logic signed [pts_pkg::DATA_W-1:0] period);
    cmd            <= c;
    now_ms         <= now;
    first_delay_ms <= delay;
    period_ms      <= period;
    start          <= 1'b1;
    while (busy) @(negedge clk);
    @(posedge clk);
    predict_request(c, now, delay, period);
    n_requests++;
    @(negedge clk);
  endtask

  task automatic pause_sender(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  always @(posedge clk) begin : result_check
    sched_result_t e;
    if (!rst && done) begin
      if (pending_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("%0t: result with no request outstanding", $realtime);
      end else begin
        e = pending_q.pop_front();
        if (fired !== e.fired || fired_task !== e.fired_task ||
            no_tasks !== e.no_tasks || wait_ms !== e.wait_ms ||
            add_accepted !== e.add_accepted || add_index !== e.add_index) begin
          n_mismatch++;
          if (n_mismatch <= 10) begin
            $display("%0t: expected fired=%0b task=%0d empty=%0b wait=%0d acc=%0b idx=%0d",
                     $realtime, e.fired, e.fired_task, e.no_tasks, e.wait_ms,
                     e.add_accepted, e.add_index);
            $display("%0t:   actual fired=%0b task=%0d empty=%0b wait=%0d acc=%0b idx=%0d",
                     $realtime, fired, fired_task, no_tasks, wait_ms,
                     add_accepted, add_index);
          end
        end
      end
    end
  end

  task automatic test_empty_table();
    send_request(pts_pkg::CMD_POLL, 32'sd0, 32'sd0, 32'sd0);
    pause_sender(3);
    send_request(pts_pkg::CMD_POLL, INT_MIN, INT_MAX, INT_MIN);
  endtask

  task automatic test_add_and_fire();
    send_request(pts_pkg::CMD_ADD, 32'sd0, 32'sd0, 32'sd100);
    send_request(pts_pkg::CMD_POLL, 32'sd0, 32'sd0, 32'sd0);
    // due time wraps to the most negative value
    send_request(pts_pkg::CMD_ADD, INT_MAX, 32'sd1, -32'sd1);
    send_request(pts_pkg::CMD_POLL, INT_MIN, 32'sd0, 32'sd0);
    // tie with task 0 at due 100
    send_request(pts_pkg::CMD_ADD, 32'sd100, 32'sd0, INT_MAX);
    pause_sender(7);
    send_request(pts_pkg::CMD_POLL, 32'sd100, 32'sd0, 32'sd0);
    send_request(pts_pkg::CMD_POLL, 32'sd99, 32'sd0, 32'sd0);
  endtask

  task automatic test_table_full();
    send_request(pts_pkg::CMD_ADD, -32'sd5, INT_MIN, INT_MIN);
    send_request(pts_pkg::CMD_ADD, 32'sh12345678, -32'sd1, -32'sd1);
    send_request(pts_pkg::CMD_ADD, 32'shaaaaaaaa, INT_MAX, 32'sh55555555);
    send_request(pts_pkg::CMD_ADD, 32'sd1000, 32'sd50, 32'sd10);
    send_request(pts_pkg::CMD_ADD, 32'sd1000, 32'sh55555555, 32'shaaaaaaaa);
    send_request(pts_pkg::CMD_ADD, -32'sd1, -32'sd1, -32'sd1);
    send_request(pts_pkg::CMD_ADD, 32'sd0, 32'sd0, 32'sd0);
  endtask

  task automatic test_extreme_times();
    send_request(pts_pkg::CMD_POLL, INT_MAX, 32'sd0, 32'sd0);
    send_request(pts_pkg::CMD_POLL, INT_MIN, 32'sd0, 32'sd0);
    send_request(pts_pkg::CMD_POLL, 32'sd0, 32'sd0, 32'sd0);
  endtask

  task automatic test_random_traffic(input int count);
    int sel;
    logic signed [pts_pkg::DATA_W-1:0] target;
    logic signed [pts_pkg::DATA_W-1:0] now;
    for (int i = 0; i < count; i++) begin
      if (i < count - QUIET_TAIL && $urandom_range(0, 3) == 0)
        pause_sender($urandom_range(1, 15));
      target = (n_tasks > 0) ? due_tbl[earliest_task()] : 32'sd0;
      sel = $urandom_range(0, 99);
      if (sel < 10) begin
        send_request(pts_pkg::CMD_ADD, $urandom, $urandom, $urandom);
      end else begin
        if (sel < 55)
          now = target + ($urandom_range(0, 4) - 2);
        else if (sel < 75)
          now = target + ($urandom_range(0, 2000) - 1000);
        else if (sel < 90)
          now = $urandom;
        else
          case ($urandom_range(0, 3))
            0: now = INT_MAX;
            1: now = INT_MIN;
            2: now = 32'sd0;
            default: now = -32'sd1;
          endcase
        send_request(pts_pkg::CMD_POLL, now, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    rst            = 1'b1;
    start          = 1'b0;
    cmd            = pts_pkg::CMD_ADD;
    now_ms         = '0;
    first_delay_ms = '0;
    period_ms      = '0;
    n_tasks        = 0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_empty_table();
    test_add_and_fire();
    test_table_full();
    test_extreme_times();
    test_random_traffic(NUM_RANDOM);

    start <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);

    $display("Sent %0d requests: %0d adds stored, %0d adds refused on a full table",
             n_requests, n_added, n_refused);
    $display("%0d polls: %0d fired a task, %0d on an empty table; %0d mismatches",
             n_polls, n_fired, n_empty, n_mismatch);
    if (n_mismatch == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout waiting for the scheduler");
    $display("Simulation FAILED");
    $finish;
  end

endmodule
